@@ sv/pqrc_pkg.sv @@
package pqrc_pkg;

    localparam int COORD_W   = 16;
    localparam int PORT_W    = 4;
    localparam int CORNER_W  = 3 * COORD_W;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int TERM_W    = 2 * DIFF_W;
    localparam int DOT_W     = TERM_W + 2;
    localparam int SPLIT_W   = DOT_W / 2;
    localparam int PROD_W    = 2 * DOT_W;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CORNER_A = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_B = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_C = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_D = 8'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] ue_x;
        logic signed [COORD_W-1:0] ue_y;
        logic signed [COORD_W-1:0] ue_z;
        logic [PORT_W-1:0]         source_port;
    } t_in_item;

    typedef struct packed {
        logic              in_danger;
        logic [PORT_W-1:0] reply_port;
    } t_out_item;

    // load enables for the two register levels of the wide multiplier
    typedef struct packed {
        logic load_part;
        logic load_sum;
    } t_mul_en;

endpackage

@@ sv/pqrc_wmul.sv @@
module pqrc_wmul (
    input  logic                                 i_clk,
    input  pqrc_pkg::t_mul_en                    i_en,
    input  logic signed [pqrc_pkg::DOT_W-1:0]    i_a,
    input  logic signed [pqrc_pkg::DOT_W-1:0]    i_b,
    output logic signed [pqrc_pkg::PROD_W-1:0]   o_p
);
    import pqrc_pkg::*;

    localparam int HI_W = DOT_W - SPLIT_W;

    // low halves are unsigned, carried with a zero sign bit
    logic signed [SPLIT_W:0]          a_lo, b_lo;
    logic signed [HI_W-1:0]           a_hi, b_hi;
    logic signed [2*HI_W-1:0]         r_hh;
    logic signed [HI_W+SPLIT_W:0]     r_hl, r_lh;
    logic signed [2*SPLIT_W+1:0]      r_ll;
    logic signed [PROD_W-1:0]         r_p;

    assign a_lo = {1'b0, i_a[SPLIT_W-1:0]};
    assign b_lo = {1'b0, i_b[SPLIT_W-1:0]};
    assign a_hi = i_a[DOT_W-1:SPLIT_W];
    assign b_hi = i_b[DOT_W-1:SPLIT_W];

    always_ff @(posedge i_clk) begin
        if (i_en.load_part) begin
            r_hh <= a_hi * b_hi;
            r_hl <= a_hi * b_lo;
            r_lh <= a_lo * b_hi;
            r_ll <= a_lo * b_lo;
        end
        if (i_en.load_sum) begin
            r_p <= (PROD_W'(r_hh) <<< (2 * SPLIT_W))
                 + ((PROD_W'(r_hl) + PROD_W'(r_lh)) <<< SPLIT_W)
                 + PROD_W'(r_ll);
        end
    end

    assign o_p = r_p;

endmodule

@@ sv/point_in_quad_region_check.sv @@
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
// out     | output    | o_out_valid / i_out_stall  | o_out_data (t_out_item)
// cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Seven register stages: differences, coordinate products, dot products,
// partial products, wide products, determinant terms, result. One item per
// cycle unless the output stalls. The 36x36 products are formed in halves.
// Synchronous active-low reset empties the pipeline and clears the corners.
// A stalled output holds; earlier stages keep filling bubbles behind it.
// Items from a port at or above PORT_COUNT are taken and dropped.
module point_in_quad_region_check #(
    parameter int PORT_COUNT = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  pqrc_pkg::t_in_item                     i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output pqrc_pkg::t_out_item                    o_out_data,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [pqrc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pqrc_pkg::CORNER_W-1:0]          i_cfg_data
);
    import pqrc_pkg::*;

    localparam int NSTAGE = 7;
    localparam int DET_W  = PROD_W + 2;
    localparam int DOT_N  = 8;
    localparam int MUL_N  = 12;

    // edge vectors relative to A: u = B-A, v = C-A, w = D-A, p = P-A
    localparam int VEC_U = 0;
    localparam int VEC_V = 1;
    localparam int VEC_W = 2;
    localparam int VEC_P = 3;

    // dots: uu uv vv vw ww pu pv pw
    localparam int DOT_LHS [DOT_N] = '{VEC_U, VEC_U, VEC_V, VEC_V, VEC_W, VEC_P, VEC_P, VEC_P};
    localparam int DOT_RHS [DOT_N] = '{VEC_U, VEC_V, VEC_V, VEC_W, VEC_W, VEC_U, VEC_V, VEC_W};

    // per triangle: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20
    localparam int MUL_L [MUL_N] = '{0, 1, 2, 1, 0, 1,   2, 3, 4, 3, 2, 3};
    localparam int MUL_R [MUL_N] = '{2, 1, 5, 6, 6, 5,   4, 3, 6, 7, 7, 6};

    logic [CORNER_W-1:0]          r_corner_a, r_corner_b, r_corner_c, r_corner_d;
    logic [NSTAGE-1:0]            r_vld;
    logic [NSTAGE-1:0]            stage_go;
    logic [PORT_W-1:0]            r_port [NSTAGE-1];
    logic                         port_ok;
    logic signed [COORD_W-1:0]    pt [3];
    logic signed [DIFF_W-1:0]     r0_vec [4][3];
    logic signed [TERM_W-1:0]     r1_m [DOT_N][3];
    logic signed [DOT_W-1:0]      r2_dot [DOT_N];
    logic signed [PROD_W-1:0]     prod [MUL_N];
    logic signed [DET_W-1:0]      r5_den [2];
    logic signed [DET_W-1:0]      r5_nu [2];
    logic signed [DET_W-1:0]      r5_nv [2];
    logic [1:0]                   hit;
    t_out_item                    r_out;
    t_mul_en                      mul_en;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner_a <= '0;
            r_corner_b <= '0;
            r_corner_c <= '0;
            r_corner_d <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_CORNER_A: r_corner_a <= i_cfg_data;
                REG_CORNER_B: r_corner_b <= i_cfg_data;
                REG_CORNER_C: r_corner_c <= i_cfg_data;
                REG_CORNER_D: r_corner_d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage k loads when it is empty or its item moves on
    always_comb begin
        stage_go[NSTAGE-1] = !r_vld[NSTAGE-1] || !i_out_stall;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            stage_go[k] = !r_vld[k] || stage_go[k+1];
        end
    end

    assign o_in_stall = !stage_go[0];
    assign port_ok    = 9'(i_in_data.source_port) < 9'(PORT_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_go[0]) begin
                r_vld[0] <= i_in_valid && port_ok;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (stage_go[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_go[0]) begin
            r_port[0] <= i_in_data.source_port;
        end
        for (int k = 1; k < NSTAGE - 1; k++) begin
            if (stage_go[k]) begin
                r_port[k] <= r_port[k-1];
            end
        end
    end

    // stage 0: edge vectors
    assign pt[0] = i_in_data.ue_x;
    assign pt[1] = i_in_data.ue_y;
    assign pt[2] = i_in_data.ue_z;

    always_ff @(posedge i_clk) begin
        if (stage_go[0]) begin
            for (int k = 0; k < 3; k++) begin
                r0_vec[VEC_U][k] <= DIFF_W'($signed(r_corner_b[k*COORD_W +: COORD_W]))
                                  - DIFF_W'($signed(r_corner_a[k*COORD_W +: COORD_W]));
                r0_vec[VEC_V][k] <= DIFF_W'($signed(r_corner_c[k*COORD_W +: COORD_W]))
                                  - DIFF_W'($signed(r_corner_a[k*COORD_W +: COORD_W]));
                r0_vec[VEC_W][k] <= DIFF_W'($signed(r_corner_d[k*COORD_W +: COORD_W]))
                                  - DIFF_W'($signed(r_corner_a[k*COORD_W +: COORD_W]));
                r0_vec[VEC_P][k] <= DIFF_W'(pt[k])
                                  - DIFF_W'($signed(r_corner_a[k*COORD_W +: COORD_W]));
            end
        end
    end

    // stages 1 and 2: coordinate products, then dot sums
    for (genvar g = 0; g < DOT_N; g++) begin : g_dot
        always_ff @(posedge i_clk) begin
            if (stage_go[1]) begin
                for (int k = 0; k < 3; k++) begin
                    r1_m[g][k] <= r0_vec[DOT_LHS[g]][k] * r0_vec[DOT_RHS[g]][k];
                end
            end
            if (stage_go[2]) begin
                r2_dot[g] <= DOT_W'(r1_m[g][0]) + DOT_W'(r1_m[g][1]) + DOT_W'(r1_m[g][2]);
            end
        end
    end

    // stages 3 and 4: wide products
    assign mul_en.load_part = stage_go[3];
    assign mul_en.load_sum  = stage_go[4];

    for (genvar m = 0; m < MUL_N; m++) begin : g_mul
        pqrc_wmul u_wmul (
            .i_clk (i_clk),
            .i_en  (mul_en),
            .i_a   (r2_dot[MUL_L[m]]),
            .i_b   (r2_dot[MUL_R[m]]),
            .o_p   (prod[m])
        );
    end

    // stage 5: denominator and numerators; stage 6: sign tests
    for (genvar t = 0; t < 2; t++) begin : g_tri
        logic signed [DET_W-1:0] rest;
        logic den_zero, nu_neg, nu_zero, nv_neg, nv_zero, rest_neg, rest_zero;
        logic pos_ok, neg_ok;

        always_ff @(posedge i_clk) begin
            if (stage_go[5]) begin
                r5_den[t] <= DET_W'(prod[6*t])   - DET_W'(prod[6*t+1]);
                r5_nu[t]  <= DET_W'(prod[6*t+2]) - DET_W'(prod[6*t+3]);
                r5_nv[t]  <= DET_W'(prod[6*t+4]) - DET_W'(prod[6*t+5]);
            end
        end

        // rest = den - (nu + nv)
        assign rest      = r5_den[t] - r5_nu[t] - r5_nv[t];
        assign den_zero  = (r5_den[t] == '0);
        assign nu_neg    = r5_nu[t][DET_W-1];
        assign nu_zero   = (r5_nu[t] == '0);
        assign nv_neg    = r5_nv[t][DET_W-1];
        assign nv_zero   = (r5_nv[t] == '0);
        assign rest_neg  = rest[DET_W-1];
        assign rest_zero = (rest == '0);
        assign pos_ok    = !nu_neg && !nv_neg && !rest_neg;
        assign neg_ok    = (nu_neg || nu_zero) && (nv_neg || nv_zero) && (rest_neg || rest_zero);
        assign hit[t]    = !den_zero && (r5_den[t][DET_W-1] ? neg_ok : pos_ok);
    end

    always_ff @(posedge i_clk) begin
        if (stage_go[NSTAGE-1]) begin
            r_out.in_danger  <= |hit;
            r_out.reply_port <= r_port[NSTAGE-2];
        end
    end

    assign o_out_valid = r_vld[NSTAGE-1];
    assign o_out_data  = r_out;

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_vld))
        else $error("input stalled with a free stage");

    a_drop_bad_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (9'(i_in_data.source_port) >= 9'(PORT_COUNT)))
        |=> !r_vld[0])
        else $error("item from unserved port entered pipeline");

    a_blocked_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTAGE-2] && !stage_go[NSTAGE-2]) |=> r_vld[NSTAGE-2])
        else $error("blocked item lost");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import pqrc_pkg::*;

    localparam int PORTS       = 16;
    localparam int SETTLE_CYC  = 16;   // well past the seven-stage pipeline depth
    localparam int ANSWER_WAIT = 4000;

    // indexes past the corner registers; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 8'hFF;

    typedef logic signed [127:0] t_wide;
    typedef struct {
        longint x;
        longint y;
        longint z;
    } t_pt;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CORNER_W-1:0]  i_cfg_data  = '0;

    t_in_item            reports_pending[$];
    t_out_item           answers_due[$];
    t_out_item           answer_head;
    logic [CORNER_W-1:0] corner_shadow[4] = '{default: '0};
    int                  send_gap   = 0;
    int                  stall_left = 0;
    bit                  gaps_on    = 1'b0;
    bit                  stalls_on  = 1'b0;
    int                  failures   = 0;

    point_in_quad_region_check #(
        .PORT_COUNT(PORTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- geometry

    function automatic t_pt corner_pt(logic [CORNER_W-1:0] c);
        t_pt r;
        r.x = longint'($signed(c[COORD_W-1:0]));
        r.y = longint'($signed(c[2*COORD_W-1:COORD_W]));
        r.z = longint'($signed(c[3*COORD_W-1:2*COORD_W]));
        return r;
    endfunction

    function automatic t_pt diff(t_pt a, t_pt b);
        t_pt r;
        r.x = a.x - b.x;
        r.y = a.y - b.y;
        r.z = a.z - b.z;
        return r;
    endfunction

    function automatic longint dotp(t_pt a, t_pt b);
        return a.x * b.x + a.y * b.y + a.z * b.z;
    endfunction

    // barycentric test without the divide: numerators judged against the
    // sign of the denominator, zero denominator means outside
    function automatic bit in_tri(t_pt p, t_pt a, t_pt b, t_pt c);
        t_pt    e0, e1, e2;
        longint d00, d01, d11, d20, d21;
        t_wide  den, nu, nv, sum;
        e0  = diff(b, a);
        e1  = diff(c, a);
        e2  = diff(p, a);
        d00 = dotp(e0, e0);
        d01 = dotp(e0, e1);
        d11 = dotp(e1, e1);
        d20 = dotp(e2, e0);
        d21 = dotp(e2, e1);
        den = t_wide'(d00) * t_wide'(d11) - t_wide'(d01) * t_wide'(d01);
        nu  = t_wide'(d11) * t_wide'(d20) - t_wide'(d01) * t_wide'(d21);
        nv  = t_wide'(d00) * t_wide'(d21) - t_wide'(d01) * t_wide'(d20);
        sum = nu + nv;
        if (den == 0) begin
            return 1'b0;
        end
        if (den > 0) begin
            return nu >= 0 && nv >= 0 && den - sum >= 0;
        end
        return nu <= 0 && nv <= 0 && sum - den >= 0;
    endfunction

    function automatic t_out_item danger_answer(t_in_item rep);
        t_out_item ans;
        t_pt       p, a, b, c, d;
        p.x = longint'(rep.ue_x);
        p.y = longint'(rep.ue_y);
        p.z = longint'(rep.ue_z);
        a = corner_pt(corner_shadow[REG_CORNER_A]);
        b = corner_pt(corner_shadow[REG_CORNER_B]);
        c = corner_pt(corner_shadow[REG_CORNER_C]);
        d = corner_pt(corner_shadow[REG_CORNER_D]);
        ans.in_danger  = in_tri(p, a, b, c) || in_tri(p, a, c, d);
        ans.reply_port = rep.source_port;
        return ans;
    endfunction

    // ---------------------------------------------------------------- helpers

    function automatic int pick_gap(bit enabled);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enabled || roll < 55) begin
            return 0;
        end
        if (roll < 88) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    function automatic int srand(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic logic signed [COORD_W-1:0] sat16(longint v);
        if (v > 32767) begin
            v = 32767;
        end else if (v < -32768) begin
            v = -32768;
        end
        return COORD_W'(v);
    endfunction

    function automatic logic [CORNER_W-1:0] pack_corner(int x, int y, int z);
        return {COORD_W'(z), COORD_W'(y), COORD_W'(x)};
    endfunction

    function automatic void queue_report(int x, int y, int z, int port);
        t_in_item rep;
        rep.ue_x        = COORD_W'(x);
        rep.ue_y        = COORD_W'(y);
        rep.ue_z        = COORD_W'(z);
        rep.source_port = PORT_W'(port);
        reports_pending = {reports_pending, rep};
    endfunction

    // mostly points aimed at the region: inside, on corners, on edges,
    // pushed off the plane; the rest anywhere in the coordinate range
    function automatic t_in_item random_report();
        t_in_item    rep;
        t_pt         q[4];
        t_pt         e0, e1, p;
        logic [63:0] noise;
        int          pick, i, k, u, v;
        noise = {$urandom, $urandom};
        rep   = noise[$bits(t_in_item)-1:0];
        pick  = $urandom_range(0, 9);
        if (pick < 3) begin
            return rep;
        end
        for (i = 0; i < 4; i++) begin
            q[i] = corner_pt(corner_shadow[i]);
        end
        i = $urandom_range(0, 3);
        if (pick == 3) begin
            p = q[i];
        end else if (pick == 4) begin
            k = (i + int'($urandom_range(1, 2))) % 4;
            p.x = (q[i].x + q[k].x) / 2;
            p.y = (q[i].y + q[k].y) / 2;
            p.z = (q[i].z + q[k].z) / 2;
        end else begin
            k  = $urandom_range(1, 2);   // triangle ABC or ACD
            e0 = diff(q[k], q[0]);
            e1 = diff(q[k + 1], q[0]);
            u  = $urandom_range(0, 256);
            v  = $urandom_range(0, 256 - u);
            p.x = q[0].x + (longint'(u) * e0.x + longint'(v) * e1.x) / 256
                + longint'(srand(4));
            p.y = q[0].y + (longint'(u) * e0.y + longint'(v) * e1.y) / 256
                + longint'(srand(4));
            p.z = q[0].z + (longint'(u) * e0.z + longint'(v) * e1.z) / 256
                + longint'(srand(4));
        end
        if ($urandom_range(0, 4) == 0) begin
            p.z += longint'(srand(4000));
        end
        rep.ue_x = sat16(p.x);
        rep.ue_y = sat16(p.y);
        rep.ue_z = sat16(p.z);
        return rep;
    endfunction

    // ---------------------------------------------------------------- config

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CORNER_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx <= REG_CORNER_D) begin
            corner_shadow[idx[1:0]] = val;
        end
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_quad(input logic [CORNER_W-1:0] a, b, c, d);
        write_reg(REG_CORNER_A, a);
        write_reg(REG_CORNER_B, b);
        write_reg(REG_CORNER_C, c);
        write_reg(REG_CORNER_D, d);
    endtask

    task automatic random_quad();
        int                  shape, r, cx, cy, cz, dx, dy, dz;
        logic [CORNER_W-1:0] a, b, c, d;
        shape = $urandom_range(0, 9);
        r  = (shape < 2) ? $urandom_range(2, 24) : $urandom_range(50, 12000);
        cx = srand(8000);
        cy = srand(8000);
        cz = srand(8000);
        if (shape < 6 || shape == 8) begin
            // flat quad in a z plane, corners spread around the center
            a = pack_corner(cx - $urandom_range(0, r), cy - $urandom_range(0, r), cz);
            b = pack_corner(cx + $urandom_range(0, r), cy - $urandom_range(0, r), cz);
            c = pack_corner(cx + $urandom_range(0, r), cy + $urandom_range(0, r), cz);
            d = pack_corner(cx - $urandom_range(0, r), cy + $urandom_range(0, r), cz);
            if (shape == 8) begin
                b = a;
            end
        end else if (shape < 8) begin
            a = pack_corner(cx + srand(r), cy + srand(r), cz + srand(r));
            b = pack_corner(cx + srand(r), cy + srand(r), cz + srand(r));
            c = pack_corner(cx + srand(r), cy + srand(r), cz + srand(r));
            d = pack_corner(cx + srand(r), cy + srand(r), cz + srand(r));
        end else begin
            // all corners on one line
            dx = srand(2000);
            dy = srand(2000);
            dz = srand(2000);
            a = pack_corner(cx, cy, cz);
            b = pack_corner(cx + dx, cy + dy, cz + dz);
            c = pack_corner(cx + 2 * dx, cy + 2 * dy, cz + 2 * dz);
            d = pack_corner(cx + 3 * dx, cy + 3 * dy, cz + 3 * dz);
        end
        set_quad(a, b, c, d);
        if ($urandom_range(0, 3) == 0) begin
            write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)),
                      CORNER_W'({$urandom, $urandom}));
        end
    endtask

    // wait until every report is taken and answered, then let the pipe empty
    task automatic settle();
        int waited;
        do @(negedge i_clk); while (reports_pending.size() != 0 || i_in_valid);
        for (waited = 0; waited < ANSWER_WAIT && answers_due.size() != 0; waited++) begin
            @(negedge i_clk);
        end
        if (answers_due.size() != 0) begin
            $error("%0d answers never arrived", answers_due.size());
            failures++;
            answers_due.delete();
        end
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall && int'(i_in_data.source_port) < PORTS) begin
                answers_due = {answers_due, danger_answer(i_in_data)};
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (reports_pending.size() != 0) begin
                    i_in_data  <= reports_pending.pop_front();
                    i_in_valid <= 1'b1;
                    send_gap = pick_gap(gaps_on);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    $error("unexpected item on reply_port %0d", o_out_data.reply_port);
                    failures++;
                end else begin
                    answer_head = answers_due.pop_front();
                    if (o_out_data.in_danger !== answer_head.in_danger) begin
                        $error("in_danger: expected %0b, got %0b",
                               answer_head.in_danger, o_out_data.in_danger);
                        failures++;
                    end
                    if (o_out_data.reply_port !== answer_head.reply_port) begin
                        $error("reply_port: expected %0d, got %0d",
                               answer_head.reply_port, o_out_data.reply_port);
                        failures++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                stall_left = pick_gap(stalls_on);
                i_out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    initial begin
        int n, ph;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corners still at reset: every triangle collapses, nothing inside
        queue_report(0, 0, 0, 0);
        queue_report(32767, -32768, 0, 15);
        settle();

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        set_quad(pack_corner(-100, -100, 0), pack_corner(100, -100, 0),
                 pack_corner(100, 100, 0), pack_corner(-100, 100, 0));
        write_reg(REG_UNUSED_LO, '1);
        write_reg(REG_UNUSED_HI, CORNER_W'({$urandom, $urandom}));
        queue_report(0, 0, 0, 1);
        queue_report(-100, -100, 0, 2);     // corner A
        queue_report(100, 100, 0, 3);       // corner C, on the shared diagonal
        queue_report(-100, 100, 0, 4);
        queue_report(100, 0, 0, 5);         // on edge BC
        queue_report(0, -100, 0, 6);
        queue_report(101, 0, 0, 7);         // one step outside
        queue_report(0, -101, 0, 8);
        queue_report(50, -50, 0, 9);
        queue_report(-50, 50, 0, 10);
        queue_report(0, 0, 32767, 11);      // far off the plane, projects inside
        queue_report(-1, -1, -32768, 12);
        settle();

        // whole coordinate range in the lowest z plane
        set_quad(pack_corner(-32768, -32768, -32768), pack_corner(32767, -32768, -32768),
                 pack_corner(32767, 32767, -32768), pack_corner(-32768, 32767, -32768));
        queue_report(32767, 32767, 32767, 13);
        queue_report(-32768, -32768, -32768, 14);
        queue_report(-32768, 32767, 0, 0);
        queue_report(32767, -1, 5, 15);
        settle();

        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        set_quad(pack_corner(0, 0, 0), pack_corner(10, 10, 10),
                 pack_corner(20, 20, 20), pack_corner(30, 30, 30));
        queue_report(10, 10, 10, 1);
        queue_report(0, 0, 0, 2);
        settle();

        set_quad('1, '1, '1, '1);
        queue_report(-1, -1, -1, 3);
        settle();

        for (ph = 0; ph < 8; ph++) begin
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            random_quad();
            for (n = 0; n < 50; n++) begin
                reports_pending = {reports_pending, random_report()};
            end
            settle();
        end

        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
